// File: hdl/fvmm_pkg.sv
// Shared types, constants and float helpers for the float vector-matrix multiply core.
// No dependencies.
package fvmm_pkg;

  localparam int MAX_VECTOR_LEN = 1024;
  localparam int MAX_COLUMNS    = 1024;
  localparam int LEN_W          = 11;
  localparam int IDX_W          = 10;

  localparam logic [1:0] REG_VECTOR_LENGTH  = 2'd0;
  localparam logic [1:0] REG_MATRIX_WIDTH   = 2'd1;
  localparam logic [1:0] REG_ELEMENT_FORMAT = 2'd2;

  localparam logic FMT_HALF   = 1'b0;
  localparam logic FMT_SINGLE = 1'b1;

  localparam logic [31:0] QNAN_SINGLE = 32'h7FC0_0000;
  localparam logic [31:0] QNAN_HALF   = 32'h0000_7E00;

  typedef struct packed {
    logic [31:0]      a;
    logic [31:0]      b;
    logic             end_col;
    logic [IDX_W-1:0] col;
    logic             last;
  } queue_item_t;

  typedef struct packed {
    logic               sign;
    logic signed [10:0] exp;
    logic [23:0]        sig;
    logic               zero;
    logic               inf;
    logic               nan;
  } fp_unpack_t;

  // value = sig * 2^(exp - 23), half precision aligned to the same 24-bit significand
  function automatic fp_unpack_t fp_decode(input logic [31:0] bits, input logic fmt);
    fp_unpack_t u;
    logic [7:0]  ef8;
    logic [22:0] m23;
    logic [4:0]  ef5;
    logic [9:0]  m10;
    ef8 = bits[30:23];
    m23 = bits[22:0];
    ef5 = bits[14:10];
    m10 = bits[9:0];
    if (fmt == FMT_SINGLE) begin
      u.sign = bits[31];
      u.nan  = (ef8 == 8'hFF) && (m23 != 23'd0);
      u.inf  = (ef8 == 8'hFF) && (m23 == 23'd0);
      u.sig  = {ef8 != 8'd0, m23};
      u.exp  = (ef8 == 8'd0) ? -11'sd126 : $signed({3'b000, ef8}) - 11'sd127;
    end else begin
      u.sign = bits[15];
      u.nan  = (ef5 == 5'h1F) && (m10 != 10'd0);
      u.inf  = (ef5 == 5'h1F) && (m10 == 10'd0);
      u.sig  = {ef5 != 5'd0, m10, 13'd0};
      u.exp  = (ef5 == 5'd0) ? -11'sd14 : $signed({6'd0, ef5}) - 11'sd15;
    end
    u.zero = (u.sig == 24'd0);
    return u;
  endfunction

  function automatic logic [2:0] lead_zeros8(input logic [7:0] v);
    logic [2:0] n;
    logic       hit;
    n   = 3'd0;
    hit = 1'b0;
    for (int i = 7; i >= 0; i--) begin
      if (!hit) begin
        if (v[i]) hit = 1'b1;
        else n = n + 3'd1;
      end
    end
    return n;
  endfunction

endpackage

// File: hdl/fvmm_front.sv
// Front end: takes items, keeps the vector store and the row/column counters,
// reads the vector element for each matrix element. Depends on fvmm_pkg.
module fvmm_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      accept,
  input  logic                      opcode,
  input  logic [31:0]               value_bits,
  input  logic                      fmt,
  input  logic [fvmm_pkg::LEN_W-1:0] k_len,
  input  logic [fvmm_pkg::LEN_W-1:0] n_len,
  output logic                      push,
  output fvmm_pkg::queue_item_t     push_item
);
  import fvmm_pkg::*;

  logic [31:0] store [0:MAX_VECTOR_LEN-1];
  logic [31:0] rd_data;

  logic [IDX_W-1:0] load_index;
  logic [IDX_W-1:0] row_index;
  logic [IDX_W-1:0] column_counter;

  logic             s1_valid;
  logic [31:0]      s1_b;
  logic             s1_end;
  logic [IDX_W-1:0] s1_col;
  logic             s1_last;

  logic [IDX_W-1:0] li_eff, li_next, row_eff, cc_eff;
  logic [LEN_W-1:0] li_inc, row_inc, cc_inc, k_m1;
  logic             end_col, last;

  always_comb begin
    k_m1    = k_len - 11'd1;
    li_eff  = ({1'b0, load_index} >= k_len) ? '0 : load_index;
    li_inc  = {1'b0, li_eff} + 11'd1;
    li_next = (li_inc >= k_len) ? '0 : li_inc[IDX_W-1:0];
    row_eff = ({1'b0, row_index} >= k_len) ? k_m1[IDX_W-1:0] : row_index;
    row_inc = {1'b0, row_eff} + 11'd1;
    end_col = (row_inc >= k_len);
    cc_eff  = ({1'b0, column_counter} >= n_len) ? '0 : column_counter;
    cc_inc  = {1'b0, cc_eff} + 11'd1;
    last    = (cc_inc >= n_len);
  end

  always_ff @(posedge clk) begin
    if (accept && !opcode) begin
      store[li_eff] <= (fmt == FMT_SINGLE) ? value_bits : {16'd0, value_bits[15:0]};
    end
    rd_data <= store[row_eff];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_index     <= '0;
      row_index      <= '0;
      column_counter <= '0;
      s1_valid       <= 1'b0;
    end else begin
      s1_valid <= accept && opcode;
      if (accept && !opcode) begin
        load_index <= li_next;
      end
      if (accept && opcode) begin
        if (end_col) begin
          row_index      <= '0;
          column_counter <= last ? '0 : cc_inc[IDX_W-1:0];
        end else begin
          row_index <= row_inc[IDX_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && opcode) begin
      s1_b    <= value_bits;
      s1_end  <= end_col;
      s1_col  <= cc_eff;
      s1_last <= last;
    end
  end

  assign push              = s1_valid;
  assign push_item.a       = rd_data;
  assign push_item.b       = s1_b;
  assign push_item.end_col = s1_end;
  assign push_item.col     = s1_col;
  assign push_item.last    = s1_last;

endmodule

// File: hdl/fvmm_queue.sv
// Two-entry queue of matrix items between front end and arithmetic back end.
// Depends on fvmm_pkg.
module fvmm_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  fvmm_pkg::queue_item_t push_item,
  input  logic                  pop,
  output logic                  head_valid,
  output fvmm_pkg::queue_item_t head_item,
  output logic [1:0]            count
);
  import fvmm_pkg::*;

  queue_item_t entry [0:1];
  logic        wr_ptr;
  logic        rd_ptr;

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  assign head_valid = (count != 2'd0);
  assign head_item  = entry[rd_ptr];

endmodule

// File: hdl/fvmm_back.sv
// Back end: multiply then add, each rounded to nearest even, through one shared
// normalize/round unit; holds the accumulator and drives results. Depends on fvmm_pkg.
module fvmm_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      fmt,
  input  logic                      head_valid,
  input  fvmm_pkg::queue_item_t     head_item,
  output logic                      pop,
  output logic                      result_valid,
  output logic [31:0]               result_bits,
  output logic [fvmm_pkg::IDX_W-1:0] column_index,
  output logic                      last_column
);
  import fvmm_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_NORM = 3'd2;
  localparam logic [2:0] S_RND1 = 3'd3;
  localparam logic [2:0] S_RND2 = 3'd4;
  localparam logic [2:0] S_ADD  = 3'd5;

  localparam logic [1:0] SPEC_NONE = 2'd0;
  localparam logic [1:0] SPEC_NAN  = 2'd1;
  localparam logic [1:0] SPEC_INF  = 2'd2;

  logic [2:0]  state;
  queue_item_t cur;
  logic        op_add;
  logic [31:0] prod;
  logic [31:0] acc;

  logic [49:0]        r_m;
  logic signed [10:0] r_t;
  logic               r_sign;
  logic [1:0]         r_spec;

  logic [23:0]        q;
  logic               g, s;
  logic signed [10:0] te;

  // multiply
  fp_unpack_t  da, db;
  logic [47:0] p;
  logic [1:0]  mul_spec;

  // add
  fp_unpack_t         dx, dy;
  logic               x_big;
  logic signed [10:0] ebig, esmall, ediff;
  logic [23:0]        sig_big, sig_small;
  logic               s_big, s_small;
  logic [4:0]         ash;
  logic [26:0]        big_ext, small_ext, small_sh, small_lost, aligned;
  logic [27:0]        sum;
  logic               sum_sign;
  logic [1:0]         add_spec;
  logic               add_inf_sign;

  // round
  logic signed [10:0] emin, bias, dd, te2, ebias;
  logic [5:0]         d6;
  logic [49:0]        ms, m_lost;
  logic               stk, inc, ovf, hidden;
  logic [24:0]        q2, qn;
  logic [2:0]         lz;
  logic [31:0]        rnd_bits;

  always_comb begin
    da       = fp_decode(cur.a, fmt);
    db       = fp_decode(cur.b, fmt);
    p        = da.sig * db.sig;
    mul_spec = SPEC_NONE;
    if (da.nan || db.nan || (da.inf && db.zero) || (db.inf && da.zero)) mul_spec = SPEC_NAN;
    else if (da.inf || db.inf) mul_spec = SPEC_INF;
  end

  always_comb begin
    dx        = fp_decode(acc, fmt);
    dy        = fp_decode(prod, fmt);
    x_big     = (dx.exp >= dy.exp);
    ebig      = x_big ? dx.exp : dy.exp;
    esmall    = x_big ? dy.exp : dx.exp;
    sig_big   = x_big ? dx.sig : dy.sig;
    sig_small = x_big ? dy.sig : dx.sig;
    s_big     = x_big ? dx.sign : dy.sign;
    s_small   = x_big ? dy.sign : dx.sign;
    ediff     = ebig - esmall;
    ash       = (ediff > 11'sd31) ? 5'd31 : ediff[4:0];
    big_ext   = {sig_big, 3'b000};
    small_ext = {sig_small, 3'b000};
    small_sh  = small_ext >> ash;
    small_lost = small_ext & ~({27{1'b1}} << ash);
    aligned   = small_sh | {26'd0, |small_lost};
    if (s_big == s_small) begin
      sum      = {1'b0, big_ext} + {1'b0, aligned};
      sum_sign = s_big;
    end else if (big_ext >= aligned) begin
      sum      = {1'b0, big_ext} - {1'b0, aligned};
      sum_sign = s_big;
    end else begin
      sum      = {1'b0, aligned} - {1'b0, big_ext};
      sum_sign = s_small;
    end
    if (sum == 28'd0) sum_sign = dx.sign & dy.sign;
    add_spec     = SPEC_NONE;
    add_inf_sign = dx.inf ? dx.sign : dy.sign;
    if (dx.nan || dy.nan || (dx.inf && dy.inf && (dx.sign != dy.sign))) add_spec = SPEC_NAN;
    else if (dx.inf || dy.inf) add_spec = SPEC_INF;
  end

  always_comb begin
    lz     = lead_zeros8(r_m[49:42]);
    emin   = (fmt == FMT_SINGLE) ? -11'sd126 : -11'sd14;
    bias   = (fmt == FMT_SINGLE) ? 11'sd127 : 11'sd15;
    dd     = emin - r_t;
    d6     = (r_t >= emin) ? 6'd0 : ((dd > 11'sd63) ? 6'd63 : dd[5:0]);
    ms     = r_m >> d6;
    m_lost = r_m & ~({50{1'b1}} << d6);
    stk    = |m_lost;

    inc = g & (s | q[0]);
    q2  = {1'b0, q} + {24'd0, inc};
    ovf = (fmt == FMT_SINGLE) ? q2[24] : q2[11];
    qn  = ovf ? (q2 >> 1) : q2;
    te2 = te + $signed({10'd0, ovf});
    hidden = (fmt == FMT_SINGLE) ? qn[23] : qn[10];
    ebias  = hidden ? (te2 + bias) : 11'sd0;
    if (r_spec == SPEC_NAN) begin
      rnd_bits = (fmt == FMT_SINGLE) ? QNAN_SINGLE : QNAN_HALF;
    end else if (r_spec == SPEC_INF || (hidden && te2 > bias)) begin
      rnd_bits = (fmt == FMT_SINGLE) ? {r_sign, 8'hFF, 23'd0}
                                     : {16'd0, r_sign, 5'h1F, 10'd0};
    end else begin
      rnd_bits = (fmt == FMT_SINGLE) ? {r_sign, ebias[7:0], qn[22:0]}
                                     : {16'd0, r_sign, ebias[4:0], qn[9:0]};
    end
  end

  assign pop = (state == S_IDLE) && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      acc          <= 32'd0;
      result_valid <= 1'b0;
      op_add       <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (head_valid) state <= S_MUL;
        end
        S_MUL: begin
          op_add <= 1'b0;
          state  <= S_NORM;
        end
        S_ADD: begin
          op_add <= 1'b1;
          state  <= S_NORM;
        end
        S_NORM: begin
          if (r_spec != SPEC_NONE || r_m == 50'd0 || r_m[49]) state <= S_RND1;
        end
        S_RND1: begin
          state <= S_RND2;
        end
        S_RND2: begin
          if (!op_add) begin
            state <= S_ADD;
          end else begin
            state <= S_IDLE;
            if (cur.end_col) begin
              result_valid <= 1'b1;
              acc          <= 32'd0;
            end else begin
              acc <= rnd_bits;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (head_valid) cur <= head_item;
      end
      S_MUL: begin
        r_m    <= {2'b00, p};
        r_t    <= da.exp + db.exp + 11'sd3;
        r_sign <= da.sign ^ db.sign;
        r_spec <= mul_spec;
      end
      S_ADD: begin
        r_m    <= {sum, 22'd0};
        r_t    <= ebig + 11'sd1;
        r_sign <= (add_spec == SPEC_INF) ? add_inf_sign : sum_sign;
        r_spec <= add_spec;
      end
      S_NORM: begin
        if (!(r_spec != SPEC_NONE || r_m == 50'd0 || r_m[49])) begin
          if (r_m[49:42] == 8'd0) begin
            r_m <= r_m << 8;
            r_t <= r_t - 11'sd8;
          end else begin
            r_m <= r_m << lz;
            r_t <= r_t - $signed({8'd0, lz});
          end
        end
      end
      S_RND1: begin
        te <= (r_t < emin) ? emin : r_t;
        if (fmt == FMT_SINGLE) begin
          q <= ms[49:26];
          g <= ms[25];
          s <= (|ms[24:0]) | stk;
        end else begin
          q <= {13'd0, ms[49:39]};
          g <= ms[38];
          s <= (|ms[37:0]) | stk;
        end
      end
      S_RND2: begin
        if (!op_add) prod <= rnd_bits;
        if (op_add && cur.end_col) begin
          result_bits  <= rnd_bits;
          column_index <= cur.col;
          last_column  <= cur.last;
        end
      end
      default: ;
    endcase
  end

endmodule

// File: hdl/float_vector_matrix_multiply_core.sv
// Float vector-matrix multiply core, binary32 or binary16, round to nearest even.
// A vector load only writes the vector store. A matrix item runs in the back end through
// multiply, normalize (shifted until normalized), round, then add, normalize and
// round again in the shared normalize/round unit; the next item pops only after it finishes.
// Results are strobed for one cycle; the receiver cannot stall. Synchronous reset clears
// counters, queue, accumulator (+0) and registers (K=1, N=1, binary32); vector store is not cleared.
module float_vector_matrix_multiply_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic                       opcode,
  input  logic [31:0]                value_bits,
  output logic                       result_valid,
  output logic [31:0]                result_bits,
  output logic [fvmm_pkg::IDX_W-1:0] column_index,
  output logic                       last_column,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [1:0]                 cfg_index,
  input  logic [fvmm_pkg::LEN_W-1:0] cfg_data
);
  import fvmm_pkg::*;

  logic [LEN_W-1:0] vector_length;
  logic [LEN_W-1:0] matrix_width;
  logic             element_format;
  logic [LEN_W-1:0] k_len, n_len;

  logic        accept;
  logic        push;
  queue_item_t push_item;
  logic        pop;
  logic        head_valid;
  queue_item_t head_item;
  logic [1:0]  q_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vector_length  <= 11'd1;
      matrix_width   <= 11'd1;
      element_format <= FMT_SINGLE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_VECTOR_LENGTH:  vector_length  <= cfg_data;
        REG_MATRIX_WIDTH:   matrix_width   <= cfg_data;
        REG_ELEMENT_FORMAT: element_format <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (vector_length == 11'd0) k_len = 11'd1;
    else if (vector_length > LEN_W'(MAX_VECTOR_LEN)) k_len = LEN_W'(MAX_VECTOR_LEN);
    else k_len = vector_length;
    if (matrix_width == 11'd0) n_len = 11'd1;
    else if (matrix_width > LEN_W'(MAX_COLUMNS)) n_len = LEN_W'(MAX_COLUMNS);
    else n_len = matrix_width;
  end

  assign busy   = (({1'b0, q_count} + {2'b00, push}) >= 3'd2);
  assign accept = start && !busy;

  fvmm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .opcode     (opcode),
    .value_bits (value_bits),
    .fmt        (element_format),
    .k_len      (k_len),
    .n_len      (n_len),
    .push       (push),
    .push_item  (push_item)
  );

  fvmm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item),
    .count      (q_count)
  );

  fvmm_back u_back (
    .clk          (clk),
    .rst          (rst),
    .fmt          (element_format),
    .head_valid   (head_valid),
    .head_item    (head_item),
    .pop          (pop),
    .result_valid (result_valid),
    .result_bits  (result_bits),
    .column_index (column_index),
    .last_column  (last_column)
  );

endmodule

// File: verif/testbench.sv
// Self-checking testbench for float_vector_matrix_multiply_core.
// Drives vector loads and matrix items, predicts each column sum in both float
// formats and checks every strobed result. Depends on hdl/fvmm_pkg.sv and the core.
module testbench;
  import fvmm_pkg::*;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_MATRIX = 1'b1;
  localparam int   STALL_LIMIT = 5000;
  localparam int   SETTLE      = 40;

  typedef struct {
    logic [31:0]      sum;
    logic [IDX_W-1:0] col;
    logic             last;
  } column_sum_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                busy;
  logic                opcode = OP_LOAD;
  logic [31:0]         value_bits = '0;
  logic                result_valid;
  logic [31:0]         result_bits;
  logic [IDX_W-1:0]    column_index;
  logic                last_column;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [1:0]          cfg_index = '0;
  logic [LEN_W-1:0]    cfg_data = '0;

  float_vector_matrix_multiply_core dut (.*);

  always #4 clk = ~clk;

  // predictor state
  logic [31:0] vec_mem [MAX_VECTOR_LEN];
  int unsigned ld_ptr, row_ptr, col_ptr;
  logic [31:0] acc;
  int unsigned len_k = 1, width_n = 1;
  logic        fmt = FMT_SINGLE;

  column_sum_t pending_sums[$];
  int errors = 0, items_sent = 0, sums_seen = 0, idle_cycles = 0;
  bit quiet = 0;

  function automatic real pow2(int k);
    return $bitstoreal(longint'(k + 1023) << 52);
  endfunction

  function automatic real fp_to_real(logic [31:0] bits, logic single);
    int mb, eb, bias;
    int unsigned maxe, mant, ef;
    real v;
    mb = single ? 23 : 10;
    eb = single ? 8 : 5;
    bias = (1 << (eb - 1)) - 1;
    maxe = (1 << eb) - 1;
    mant = bits & ((1 << mb) - 1);
    ef = (bits >> mb) & maxe;
    if (ef == maxe) begin
      if (mant != 0) return $bitstoreal(64'h7FF8_0000_0000_0000);
      v = $bitstoreal(64'h7FF0_0000_0000_0000);
    end else if (ef == 0) v = real'(mant) * pow2(1 - bias - mb);
    else v = real'(mant | (1 << mb)) * pow2(int'(ef) - bias - mb);
    return bits[mb + eb] ? -v : v;
  endfunction

  function automatic logic [31:0] real_to_fp(real d, logic single);
    int mb, eb, bias, e, emin, shift;
    logic [31:0] sgn, maxe;
    logic [63:0] u, fr, sig, q, rem, halfv;
    int unsigned ef;
    bit subn;
    mb = single ? 23 : 10;
    eb = single ? 8 : 5;
    bias = (1 << (eb - 1)) - 1;
    maxe = (1 << eb) - 1;
    u = $realtobits(d);
    sgn = u[63] ? (32'd1 << (mb + eb)) : 32'd0;
    ef = 32'(u[62:52]);
    fr = {12'd0, u[51:0]};
    emin = 1 - bias;
    shift = 52 - mb;
    if (ef == 11'h7FF) begin
      if (fr != 0) return (maxe << mb) | (32'd1 << (mb - 1));
      return sgn | (maxe << mb);
    end
    if (ef == 0) return sgn;
    e = int'(ef) - 1023;
    sig = fr | (64'd1 << 52);
    subn = e < emin;
    if (subn) shift += emin - e;
    if (shift > 54) return sgn;
    q = sig >> shift;
    rem = sig & ((64'd1 << shift) - 1);
    halfv = 64'd1 << (shift - 1);
    if (rem > halfv || (rem == halfv && q[0])) q++;
    if (subn) return sgn | q[31:0];
    if ((q >> (mb + 1)) != 0) begin
      q >>= 1;
      e++;
    end
    if (e > bias) return sgn | (maxe << mb);
    return sgn | (32'(e + bias) << mb) | (q[31:0] & ((32'd1 << mb) - 1));
  endfunction

  function automatic int unsigned clamp_len(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    return v > hi ? hi : v;
  endfunction

  task automatic predict_item(logic op, logic [31:0] raw);
    int unsigned k, n;
    logic [31:0] vmask, val, a, prod;
    bit last;
    column_sum_t cs;
    k = clamp_len(len_k, MAX_VECTOR_LEN);
    n = clamp_len(width_n, MAX_COLUMNS);
    vmask = fmt ? 32'hFFFF_FFFF : 32'h0000_FFFF;
    val = raw & vmask;
    if (op == OP_LOAD) begin
      if (ld_ptr >= k) ld_ptr = 0;
      vec_mem[ld_ptr] = val;
      ld_ptr++;
      if (ld_ptr >= k) ld_ptr = 0;
      return;
    end
    if (row_ptr >= k) row_ptr = k - 1;
    a = vec_mem[row_ptr] & vmask;
    prod = real_to_fp(fp_to_real(a, fmt) * fp_to_real(val, fmt), fmt);
    acc = real_to_fp(fp_to_real(acc & vmask, fmt) + fp_to_real(prod, fmt), fmt);
    row_ptr++;
    if (row_ptr < k) return;
    if (col_ptr >= n) col_ptr = 0;
    last = col_ptr + 1 >= n;
    cs.sum = acc & vmask;
    cs.col = col_ptr[IDX_W-1:0];
    cs.last = last;
    pending_sums.push_back(cs);
    acc = '0;
    row_ptr = 0;
    col_ptr = last ? 0 : col_ptr + 1;
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch %s: got %h expected %h", what, got, want);
  endtask

  task automatic idle_burst();
    if (!quiet && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  task automatic send_item(logic op, logic [31:0] v);
    idle_burst();
    start <= 1'b1;
    opcode <= op;
    value_bits <= v;
    do @(posedge clk); while (busy);
    predict_item(op, v);
    items_sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, int unsigned data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data[LEN_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_VECTOR_LENGTH:  len_k = data & 11'h7FF;
      REG_MATRIX_WIDTH:   width_n = data & 11'h7FF;
      REG_ELEMENT_FORMAT: fmt = data[0];
      default: ;
    endcase
  endtask

  task automatic configure(int unsigned k, int unsigned n, logic f);
    drain();
    write_reg(REG_VECTOR_LENGTH, k);
    write_reg(REG_MATRIX_WIDTH, n);
    write_reg(REG_ELEMENT_FORMAT, 32'(f));
  endtask

  function automatic logic [31:0] pick_value(logic f);
    logic [31:0] r;
    int unsigned e;
    r = $urandom();
    case ($urandom_range(0, 9))
      0: return r;
      1: return {r[31:16], r[15], 5'h1F, r[9:0]};
      2: return {r[31], 8'hFF, r[22:0]};
      3: return {r[31:16], r[15], 5'h00, r[9:0]};
      4: return {r[31], 8'h00, r[22:0]};
      default: begin
        if (f == FMT_SINGLE) begin
          e = $urandom_range(100, 154);
          return {r[31], e[7:0], r[22:0]};
        end
        e = $urandom_range(8, 22);
        return {r[31:16], r[15], e[4:0], r[9:0]};
      end
    endcase
  endfunction

  // one position: full vector load, then every column in order, with extra loads when noisy
  task automatic run_position(bit noisy);
    int unsigned k, n;
    k = clamp_len(len_k, MAX_VECTOR_LEN);
    n = clamp_len(width_n, MAX_COLUMNS);
    for (int i = 0; i < k; i++) send_item(OP_LOAD, pick_value(fmt));
    for (int c = 0; c < n; c++)
      for (int r = 0; r < k; r++) begin
        if (noisy && $urandom_range(0, 15) == 0) send_item(OP_LOAD, pick_value(fmt));
        send_item(OP_MATRIX, pick_value(fmt));
      end
  endtask

  task automatic test_single_specials();
    logic [31:0] vals [8];
    vals = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
             32'h7FC0_0001, 32'h7F7F_FFFF, 32'h0000_0001, 32'h3F80_0000};
    configure(1, 2, FMT_SINGLE);
    foreach (vals[i]) begin
      send_item(OP_LOAD, vals[i]);
      send_item(OP_MATRIX, vals[(i + 3) % 8]);
    end
    send_item(OP_LOAD, 32'h7F7F_FFFF);
    send_item(OP_MATRIX, 32'h7F7F_FFFF);
    send_item(OP_LOAD, 32'h0080_0000);
    send_item(OP_MATRIX, 32'h3F00_0000);
  endtask

  task automatic test_half_specials();
    configure(2, 1, FMT_HALF);
    send_item(OP_LOAD, 32'hFFFF_7BFF);
    send_item(OP_LOAD, 32'h1234_0001);
    send_item(OP_MATRIX, 32'hABCD_7BFF);
    send_item(OP_MATRIX, 32'h0000_3C00);
    send_item(OP_MATRIX, 32'h0000_7C00);
    send_item(OP_MATRIX, 32'h0000_0000);
    send_item(OP_MATRIX, 32'hFFFF_FE01);
    send_item(OP_MATRIX, 32'h0000_8000);
  endtask

  task automatic test_length_extremes();
    configure(0, 0, FMT_SINGLE);
    run_position(0);
    configure(1, 2047, FMT_SINGLE);
    run_position(0);
  endtask

  task automatic test_random_phases(int unsigned budget);
    int unsigned stop;
    stop = items_sent + budget;
    while (items_sent < stop) begin
      configure($urandom_range(1, 8), $urandom_range(1, 8), 1'($urandom_range(0, 1)));
      repeat ($urandom_range(1, 3)) run_position(1);
    end
  endtask

  task automatic test_steady_stream();
    quiet = 1;
    configure(3, 4, FMT_SINGLE);
    run_position(0);
    configure(4, 3, FMT_HALF);
    run_position(0);
    drain();
  endtask

  always @(posedge clk) begin
    column_sum_t cs;
    if (!rst && result_valid) begin
      sums_seen++;
      if (pending_sums.size() == 0) begin
        errors++;
        $display("unexpected result %h col %0d", result_bits, column_index);
      end else begin
        cs = pending_sums.pop_front();
        if (result_bits !== cs.sum) report("sum", result_bits, cs.sum);
        if (column_index !== cs.col) report("column", 32'(column_index), 32'(cs.col));
        if (last_column !== cs.last) report("last", 32'(last_column), 32'(cs.last));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || result_valid || (start && !busy) || (cfg_valid && cfg_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout with %0d results pending", pending_sums.size());
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    ld_ptr = 0;
    row_ptr = 0;
    col_ptr = 0;
    acc = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_single_specials();
    test_half_specials();
    test_length_extremes();
    test_random_phases(700);
    test_steady_stream();
    if (pending_sums.size() != 0) begin
      errors++;
      $display("%0d results never arrived", pending_sums.size());
    end
    $display("covered %0d items and %0d column sums in both formats", items_sent, sums_seen);
    $display("length extremes, special values and random shapes with idle gaps");
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

// File: filelist.f
hdl/fvmm_pkg.sv
hdl/fvmm_front.sv
hdl/fvmm_queue.sv
hdl/fvmm_back.sv
hdl/float_vector_matrix_multiply_core.sv
verif/testbench.sv
